// ===== sv/rprop_weight_update_assert.svh =====
// assertion macros shared by the rprop weight update modules
// both sample on clk_i and are switched off while rst_ni is low
`ifndef RPROP_WEIGHT_UPDATE_ASSERT_SVH
`define RPROP_WEIGHT_UPDATE_ASSERT_SVH

// expression must be true at every edge
`define RPWU_ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// antecedent implies consequent sequence
`define RPWU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

`endif

// ===== sv/rpwu_pkg.sv =====
`timescale 1ns / 1ps
package rpwu_pkg;

  // field widths
  localparam int unsigned IdxW  = 10;
  localparam int unsigned DataW = 32;
  localparam int unsigned StepW = 31;
  localparam int unsigned FracW = 24;

  // operation codes
  typedef enum logic {
    OpLoad   = 1'b0,
    OpUpdate = 1'b1
  } op_e;

  // configuration register indexes
  localparam logic [1:0] CfgInitStep    = 2'd0;
  localparam logic [1:0] CfgMaxStep     = 2'd1;
  localparam logic [1:0] CfgWeightDecay = 2'd2;

  // step constants in Q7.24
  localparam logic [StepW-1:0] DefInitStep = 31'd1677722;
  localparam logic [StepW-1:0] DefMaxStep  = 31'd838860800;
  localparam logic [StepW-1:0] MinStep     = 31'd17;

  // rounding offset for the decay product
  localparam logic signed [63:0] RoundHalf = 64'sd8388608;

  // reciprocal of five, exact for any 32 bit dividend
  localparam logic [31:0] Recip5      = 32'd3435973837;
  localparam int unsigned Recip5Shift = 34;

  // queue between front and back, power of two
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    op_e              op;
    logic             in_range;
    logic [IdxW-1:0]  index;
    logic [DataW-1:0] value;
  } item_t;

  typedef struct packed {
    logic [StepW-1:0] init_step;
    logic [StepW-1:0] max_step;
    logic [DataW-1:0] decay;
  } cfg_t;

  // one table entry: first-update flag, step size, last step, weight
  typedef struct packed {
    logic             flag;
    logic [StepW-1:0] step;
    logic [DataW-1:0] last;
    logic [DataW-1:0] weight;
  } entry_t;

  // floor(y / 5) by reciprocal multiplication
  function automatic logic [29:0] div5(input logic [31:0] y);
    logic [63:0] p;
    p = 64'(y) * 64'(Recip5);
    return p[63:Recip5Shift];
  endfunction

endpackage

// ===== sv/rprop_weight_update.sv =====
// accepted items pass the queue, table read and stage registers before the result strobe
// throughput: one item per cycle while no item shares a weight with the four issued before it
// such an item waits at the issue stage until the older one leaves the four-stage pipeline;
// the two-entry queue then fills and busy rises
// reset: rst_ni low clears the queue, the pipeline valids and the configuration
// registers to their defaults; the weight table holds no reset state
`timescale 1ns / 1ps
module rprop_weight_update #(
  parameter int unsigned NUM_WEIGHTS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              opcode_i,
  input  logic [rpwu_pkg::IdxW-1:0]         weight_index_i,
  input  logic signed [rpwu_pkg::DataW-1:0] value_in_i,
  output logic                              result_valid_o,
  output logic [rpwu_pkg::IdxW-1:0]         index_out_o,
  output logic signed [rpwu_pkg::DataW-1:0] new_weight_o,
  output logic signed [rpwu_pkg::DataW-1:0] applied_step_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [rpwu_pkg::DataW-1:0]        cfg_data_i
);
  import rpwu_pkg::*;

  logic [StepW-1:0] init_step_q, max_step_q;
  logic [DataW-1:0] decay_q;
  cfg_t             cfg_q, cfg_d;
  logic [StepW-1:0] max_eff, init_raw;

  logic  push, full, head_valid, pop;
  item_t push_item, head_item;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_step_q <= DefInitStep;
      max_step_q  <= DefMaxStep;
      decay_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgInitStep:    init_step_q <= cfg_data_i[StepW-1:0];
        CfgMaxStep:     max_step_q  <= cfg_data_i[StepW-1:0];
        CfgWeightDecay: decay_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective values: zero picks the default, initial step clamped to max
  always_comb begin
    max_eff         = (max_step_q == '0) ? DefMaxStep : max_step_q;
    init_raw        = (init_step_q == '0) ? DefInitStep : init_step_q;
    cfg_d.max_step  = max_eff;
    cfg_d.init_step = (init_raw > max_eff) ? max_eff : init_raw;
    cfg_d.decay     = decay_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{init_step: DefInitStep, max_step: DefMaxStep, decay: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rpwu_front #(
    .NUM_WEIGHTS(NUM_WEIGHTS)
  ) u_front (
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .weight_index_i (weight_index_i),
    .value_in_i     (value_in_i),
    .full_i         (full),
    .push_o         (push),
    .item_o         (push_item)
  );

  rpwu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (push_item),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head_item),
    .pop_i        (pop)
  );

  rpwu_back #(
    .NUM_WEIGHTS(NUM_WEIGHTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head_item),
    .pop_o          (pop),
    .cfg_i          (cfg_q),
    .res_valid_o    (result_valid_o),
    .index_out_o    (index_out_o),
    .new_weight_o   (new_weight_o),
    .applied_step_o (applied_step_o)
  );

endmodule

// ===== sv/rpwu_front.sv =====
`timescale 1ns / 1ps
`include "rprop_weight_update_assert.svh"
module rpwu_front #(
  parameter int unsigned NUM_WEIGHTS = 1024
) (
  input  logic                           start,
  output logic                           busy,
  input  logic                           opcode_i,
  input  logic [rpwu_pkg::IdxW-1:0]      weight_index_i,
  input  logic signed [rpwu_pkg::DataW-1:0] value_in_i,
  input  logic                           full_i,
  output logic                           push_o,
  output rpwu_pkg::item_t                item_o
);
  import rpwu_pkg::*;

  localparam int unsigned LimW  = $clog2(NUM_WEIGHTS + 1);
  localparam int unsigned CmpW  = (LimW > IdxW) ? LimW : IdxW;

  // accept while the queue has room
  assign busy   = full_i;
  assign push_o = start && !full_i;

  // classify the item: operation and whether the index hits the table
  always_comb begin
    item_o.op       = op_e'(opcode_i);
    item_o.in_range = CmpW'(weight_index_i) < CmpW'(NUM_WEIGHTS);
    item_o.index    = weight_index_i;
    item_o.value    = value_in_i;
  end

endmodule

// ===== sv/rpwu_queue.sv =====
`timescale 1ns / 1ps
`include "rprop_weight_update_assert.svh"
module rpwu_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rpwu_pkg::item_t item_i,
  output logic            full_o,
  output logic            head_valid_o,
  output rpwu_pkg::item_t head_o,
  input  logic            pop_i
);
  import rpwu_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = PtrW + 1;

  item_t           slots_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o       = count_q == CntW'(QueueDepth);
  assign head_valid_o = count_q != '0;
  assign head_o       = slots_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

  `RPWU_ASSERT_HOLDS(a_count_bound, count_q <= CntW'(QueueDepth), "queue count above depth")
  `RPWU_ASSERT_IMPL(a_pop_nonempty, pop_i, count_q != '0, "pop from empty queue")

endmodule

// ===== sv/rpwu_back.sv =====
`timescale 1ns / 1ps
`include "rprop_weight_update_assert.svh"
module rpwu_back #(
  parameter int unsigned NUM_WEIGHTS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              head_valid_i,
  input  rpwu_pkg::item_t                   head_i,
  output logic                              pop_o,
  input  rpwu_pkg::cfg_t                    cfg_i,
  output logic                              res_valid_o,
  output logic [rpwu_pkg::IdxW-1:0]         index_out_o,
  output logic signed [rpwu_pkg::DataW-1:0] new_weight_o,
  output logic signed [rpwu_pkg::DataW-1:0] applied_step_o
);
  import rpwu_pkg::*;

  localparam int unsigned AddrW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
  localparam int unsigned ExtW  = AddrW + IdxW;

  function automatic logic [AddrW-1:0] to_addr(input logic [IdxW-1:0] idx);
    logic [ExtW-1:0] ext;
    ext = ExtW'(idx);
    return ext[AddrW-1:0];
  endfunction

  function automatic logic same_entry(input logic v, input item_t a, input item_t b);
    return v && a.in_range && b.in_range && (a.index == b.index);
  endfunction

  // weight table
  entry_t mem [NUM_WEIGHTS];
  entry_t rd_q;
  logic   rd_en, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  entry_t wr_data;

  // stage valid bits
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, res_valid_q;
  item_t s1_item_q, s2_item_q, s3_item_q, s4_item_q;

  // stage 1 signals
  logic signed [63:0] prod_d;
  logic [29:0]        quot_d;
  logic [31:0]        half_d;
  logic [StepW-1:0]   shrink_d;
  logic               last_pos_d, last_neg_d;

  // stage 2 registers and signals
  logic signed [63:0] s2_prod_q;
  logic [29:0]        s2_quot_q;
  logic [StepW-1:0]   s2_shrink_q, s2_step_q;
  logic [DataW-1:0]   s2_weight_q;
  logic               s2_last_pos_q, s2_last_neg_q, s2_flag_q;
  logic signed [63:0] prod_rnd;
  logic signed [39:0] prod_q24;
  logic signed [40:0] grad_sum;
  logic               gpos_d, gneg_d;
  logic [31:0]        grow_sum;
  logic [StepW-1:0]   growc_d;

  // stage 3 registers and signals
  logic               s3_gpos_q, s3_gneg_q;
  logic [StepW-1:0]   s3_growc_q, s3_shrink_q, s3_step_q;
  logic [DataW-1:0]   s3_weight_q;
  logic               s3_last_pos_q, s3_last_neg_q, s3_flag_q;
  logic               dir_neg, dir_pos;
  logic [StepW-1:0]   nstep_d, mag;
  logic [DataW-1:0]   rec_d;
  logic [31:0]        half5;
  logic [29:0]        tenth_d;

  // stage 4 registers and signals
  logic [DataW-1:0]   s4_rec_q, s4_weight_q;
  logic               s4_rec_neg_q, s4_flag_q;
  logic [29:0]        s4_tenth_q;
  logic [StepW-1:0]   s4_nstep_q;
  logic signed [31:0] move;
  logic signed [32:0] wsum;
  logic [DataW-1:0]   wsat, nw_d, rec_out_d;

  // result registers
  logic [IdxW-1:0]    res_index_q;
  logic [DataW-1:0]   res_weight_q, res_step_q;

  // issue: hold the head while an older item to the same entry is in flight
  logic hazard;
  assign hazard = same_entry(s1_valid_q, s1_item_q, head_i)
               || same_entry(s2_valid_q, s2_item_q, head_i)
               || same_entry(s3_valid_q, s3_item_q, head_i)
               || same_entry(s4_valid_q, s4_item_q, head_i);
  assign pop_o   = head_valid_i && !hazard;
  assign rd_en   = pop_o && head_i.in_range;
  assign rd_addr = to_addr(head_i.index);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // stage 1: decay product, grown step quotient, shrunk step
  always_comb begin
    prod_d     = $signed(cfg_i.decay) * $signed(rd_q.weight);
    quot_d     = div5(32'(rd_q.step) + 32'd2);
    half_d     = (32'(rd_q.step) + 32'd1) >> 1;
    shrink_d   = (half_d < 32'(MinStep)) ? MinStep : half_d[StepW-1:0];
    last_pos_d = !rd_q.last[DataW-1] && (rd_q.last != '0);
    last_neg_d = rd_q.last[DataW-1];
  end

  // stage 2: gradient sign and capped growth
  always_comb begin
    prod_rnd = s2_prod_q + RoundHalf;
    prod_q24 = prod_rnd[63:FracW];
    grad_sum = 41'(prod_q24) + 41'($signed(s2_item_q.value));
    gpos_d   = !grad_sum[40] && (grad_sum != '0);
    gneg_d   = grad_sum[40];
    grow_sum = 32'(s2_step_q) + 32'(s2_quot_q);
    growc_d  = (grow_sum > 32'(cfg_i.max_step)) ? cfg_i.max_step : grow_sum[StepW-1:0];
  end

  // stage 3: direction, new step, recorded step and its tenth
  always_comb begin
    dir_neg = (s3_last_pos_q && s3_gneg_q) || (s3_last_neg_q && s3_gpos_q);
    dir_pos = (s3_last_pos_q && s3_gpos_q) || (s3_last_neg_q && s3_gneg_q);
    priority if (dir_neg) begin
      nstep_d = s3_growc_q;
      mag     = s3_growc_q;
    end else if (dir_pos) begin
      nstep_d = s3_shrink_q;
      mag     = '0;
    end else begin
      nstep_d = s3_step_q;
      mag     = (s3_gpos_q || s3_gneg_q) ? s3_step_q : '0;
    end
    rec_d   = s3_gpos_q ? -32'(mag) : 32'(mag);
    half5   = (32'(mag) + 32'd5) >> 1;
    tenth_d = div5(half5);
  end

  // stage 4: move, saturating add, table write
  always_comb begin
    move = s4_flag_q ? (s4_rec_neg_q ? -$signed(32'(s4_tenth_q)) : $signed(32'(s4_tenth_q)))
                     : $signed(s4_rec_q);
    wsum = 33'($signed(s4_weight_q)) + 33'(move);
    if (wsum[32] != wsum[31]) begin
      wsat = wsum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      wsat = wsum[31:0];
    end
    unique case (s4_item_q.op)
      OpLoad: begin
        wr_data   = '{flag: 1'b1, step: cfg_i.init_step, last: '0, weight: s4_item_q.value};
        nw_d      = s4_item_q.value;
        rec_out_d = '0;
      end
      OpUpdate: begin
        wr_data   = '{flag: 1'b0, step: s4_nstep_q, last: s4_rec_q, weight: wsat};
        nw_d      = wsat;
        rec_out_d = s4_rec_q;
      end
    endcase
    wr_en   = s4_valid_q && s4_item_q.in_range;
    wr_addr = to_addr(s4_item_q.index);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= pop_o;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      res_valid_q <= s4_valid_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    s1_item_q     <= head_i;

    s2_item_q     <= s1_item_q;
    s2_prod_q     <= prod_d;
    s2_quot_q     <= quot_d;
    s2_shrink_q   <= shrink_d;
    s2_step_q     <= rd_q.step;
    s2_weight_q   <= rd_q.weight;
    s2_last_pos_q <= last_pos_d;
    s2_last_neg_q <= last_neg_d;
    s2_flag_q     <= rd_q.flag;

    s3_item_q     <= s2_item_q;
    s3_gpos_q     <= gpos_d;
    s3_gneg_q     <= gneg_d;
    s3_growc_q    <= growc_d;
    s3_shrink_q   <= s2_shrink_q;
    s3_step_q     <= s2_step_q;
    s3_weight_q   <= s2_weight_q;
    s3_last_pos_q <= s2_last_pos_q;
    s3_last_neg_q <= s2_last_neg_q;
    s3_flag_q     <= s2_flag_q;

    s4_item_q     <= s3_item_q;
    s4_rec_q      <= rec_d;
    s4_rec_neg_q  <= s3_gpos_q;
    s4_tenth_q    <= tenth_d;
    s4_nstep_q    <= nstep_d;
    s4_weight_q   <= s3_weight_q;
    s4_flag_q     <= s3_flag_q;

    res_index_q   <= s4_item_q.index;
    res_weight_q  <= s4_item_q.in_range ? nw_d : '0;
    res_step_q    <= s4_item_q.in_range ? rec_out_d : '0;
  end

  assign res_valid_o    = res_valid_q;
  assign index_out_o    = res_index_q;
  assign new_weight_o   = $signed(res_weight_q);
  assign applied_step_o = $signed(res_step_q);

  `RPWU_ASSERT_IMPL(a_no_rw_clash, rd_en && wr_en, rd_addr != wr_addr, "read of entry being written")
  `RPWU_ASSERT_IMPL(a_issue_to_result, pop_o, ##5 res_valid_q, "issued item gave no result")
  `RPWU_ASSERT_HOLDS(a_no_adjacent_same, !same_entry(s1_valid_q && s2_valid_q, s1_item_q, s2_item_q), "same entry in adjacent stages")

endmodule

// ===== tb/rprop_weight_update_test.sv =====
`timescale 1ns / 1ps
module rprop_weight_update_test;
  import rpwu_pkg::*;

  localparam logic [1:0] CfgUnused = 2'd3;
  localparam int NumPhases = 12;
  localparam int ItemsPerPhase = 130;
  localparam int TailCycles = 12;
  localparam int CycleLimit = 400000;
  localparam longint WeightMax = 64'sd2147483647;
  localparam longint WeightMin = -64'sd2147483648;

  typedef struct packed {
    logic [IdxW-1:0]  index;
    logic [DataW-1:0] weight;
    logic [DataW-1:0] step;
  } result_t;

  typedef struct {
    op_e              op;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] val;
    bit               typed;
    logic [DataW-1:0] weight;
    logic [DataW-1:0] step;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic opcode_i = 1'b0;
  logic [IdxW-1:0] weight_index_i = '0;
  logic signed [DataW-1:0] value_in_i = '0;
  logic result_valid_o;
  logic [IdxW-1:0] index_out_o;
  logic signed [DataW-1:0] new_weight_o;
  logic signed [DataW-1:0] applied_step_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [DataW-1:0] cfg_data_i = '0;

  // predictor copy of the weight table and registers
  logic signed [DataW-1:0] wt_tab[1024];
  logic signed [DataW-1:0] last_tab[1024];
  logic [DataW-1:0] step_tab[1024];
  bit flag_tab[1024];
  bit loaded[1024];
  logic [StepW-1:0] cfg_init = DefInitStep;
  logic [StepW-1:0] cfg_max = DefMaxStep;
  logic signed [DataW-1:0] cfg_decay = '0;

  result_t pending_results[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;

  // directed stimulus, expected values typed in where obvious
  stim_row_t directed_rows[19] = '{
    '{OpLoad,   10'd0,    32'h8000_0000, 1'b1, 32'h8000_0000, 32'h0},
    '{OpLoad,   10'd1023, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h0},
    '{OpLoad,   10'd5,    32'h0,         1'b1, 32'h0,         32'h0},
    '{OpLoad,   10'd6,    32'h0100_0000, 1'b1, 32'h0100_0000, 32'h0},
    '{OpUpdate, 10'd1023, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 32'd1677722},
    '{OpUpdate, 10'd0,    32'h7FFF_FFFF, 1'b1, 32'h8000_0000, -32'sd1677722},
    '{OpUpdate, 10'd5,    32'h0,         1'b1, 32'h0,         32'h0},
    '{OpUpdate, 10'd5,    32'h0000_0100, 1'b0, 32'h0,         32'h0},
    '{OpUpdate, 10'd5,    32'h0000_0100, 1'b0, 32'h0,         32'h0},
    '{OpUpdate, 10'd5,    32'hFFFF_FF00, 1'b0, 32'h0,         32'h0},
    '{OpUpdate, 10'd5,    32'hFFFF_FFFF, 1'b0, 32'h0,         32'h0},
    '{OpUpdate, 10'd6,    32'hFFFF_FF00, 1'b0, 32'h0,         32'h0},
    '{OpUpdate, 10'd6,    32'hFFFF_FF00, 1'b0, 32'h0,         32'h0},
    '{OpUpdate, 10'd6,    32'hFFFF_FF00, 1'b0, 32'h0,         32'h0},
    '{OpUpdate, 10'd1023, 32'h8000_0000, 1'b0, 32'h0,         32'h0},
    '{OpLoad,   10'd1023, 32'h5A5A_5A5A, 1'b1, 32'h5A5A_5A5A, 32'h0},
    '{OpUpdate, 10'd0,    32'h4000_0000, 1'b0, 32'h0,         32'h0},
    '{OpLoad,   10'd512,  32'hA5A5_A5A5, 1'b1, 32'hA5A5_A5A5, 32'h0},
    '{OpUpdate, 10'd512,  32'h0000_0001, 1'b0, 32'h0,         32'h0}
  };

  rprop_weight_update uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .weight_index_i (weight_index_i),
    .value_in_i     (value_in_i),
    .result_valid_o (result_valid_o),
    .index_out_o    (index_out_o),
    .new_weight_o   (new_weight_o),
    .applied_step_o (applied_step_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint eff_max_step();
    return (cfg_max != '0) ? longint'(cfg_max) : longint'(DefMaxStep);
  endfunction

  // next weight and recorded step for one load or gradient update
  function automatic result_t apply_rprop(input op_e op, input logic [IdxW-1:0] idx,
                                          input logic signed [DataW-1:0] val);
    result_t r;
    longint w, prod, g, step, init, rec, mv, mag, sum;
    int gs, ls, dir;
    r.index = idx;
    r.weight = '0;
    r.step = '0;
    if (op == OpLoad) begin
      init = (cfg_init != '0) ? longint'(cfg_init) : longint'(DefInitStep);
      if (init > eff_max_step()) init = eff_max_step();
      wt_tab[idx] = val;
      step_tab[idx] = 32'(init);
      last_tab[idx] = '0;
      flag_tab[idx] = 1'b1;
      loaded[idx] = 1'b1;
      r.weight = val;
    end else begin
      w = longint'(wt_tab[idx]);
      prod = (longint'(cfg_decay) * w + RoundHalf) >>> FracW;
      g = longint'(val) + prod;
      gs = (g > 0) ? 1 : ((g < 0) ? -1 : 0);
      ls = (last_tab[idx] > 0) ? 1 : ((last_tab[idx] < 0) ? -1 : 0);
      dir = ls * gs;
      step = longint'(step_tab[idx]);
      if (dir < 0) begin
        // same sign: grow and move against the gradient
        step = (step * 6 + 2) / 5;
        if (step > eff_max_step()) step = eff_max_step();
        rec = (gs > 0) ? -step : step;
      end else if (dir > 0) begin
        // sign change: shrink, no move
        step = (step + 1) >> 1;
        if (step < longint'(MinStep)) step = longint'(MinStep);
        rec = 0;
      end else begin
        rec = (gs > 0) ? -step : ((gs < 0) ? step : 0);
      end
      // first update after a load moves a tenth, rounded away from zero
      mv = rec;
      if (flag_tab[idx]) begin
        mag = (mv < 0) ? -mv : mv;
        mag = (mag + 5) / 10;
        mv = (mv < 0) ? -mag : mag;
      end
      sum = w + mv;
      if (sum > WeightMax) sum = WeightMax;
      else if (sum < WeightMin) sum = WeightMin;
      wt_tab[idx] = 32'(sum);
      last_tab[idx] = 32'(rec);
      step_tab[idx] = 32'(step);
      flag_tab[idx] = 1'b0;
      r.weight = 32'(sum);
      r.step = 32'(rec);
    end
    return r;
  endfunction

  // present one item after a random gap, wait for its transfer
  task automatic send_item(input op_e op, input logic [IdxW-1:0] idx,
                           input logic [DataW-1:0] val, input bit typed,
                           input logic [DataW-1:0] exp_weight,
                           input logic [DataW-1:0] exp_step);
    result_t pred;
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(0, 99) < idle_pct) begin
      if (!lowered) begin
        start <= 1'b0;
        lowered = 1'b1;
      end
      @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= op;
    weight_index_i <= idx;
    value_in_i <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pred = apply_rprop(op, idx, val);
    if (typed) begin
      pred.weight = exp_weight;
      pred.step = exp_step;
    end
    pending_results.push_back(pred);
  endtask

  // register write; valid stays up for the caller to drop
  task automatic write_reg(input logic [1:0] ix, input logic [DataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ix;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (ix)
      CfgInitStep:    cfg_init = data[StepW-1:0];
      CfgMaxStep:     cfg_max = data[StepW-1:0];
      CfgWeightDecay: cfg_decay = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // result checker
  result_t exp_r;
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result for index %0d", index_out_o);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (index_out_o !== exp_r.index) begin
          $error("index_out: expected %0d, got %0d", exp_r.index, index_out_o);
          mismatch_count++;
        end
        if (new_weight_o !== exp_r.weight) begin
          $error("new_weight: expected %0d, got %0d", $signed(exp_r.weight), new_weight_o);
          mismatch_count++;
        end
        if (applied_step_o !== exp_r.step) begin
          $error("applied_step: expected %0d, got %0d", $signed(exp_r.step),
                 applied_step_o);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("rprop_weight_update_test: FAIL");
      $finish;
    end
  end

  initial begin
    logic [IdxW-1:0] hot[8];
    bit neg_trend[1024];
    int idle_modes[3];
    int flip_pct, r;
    logic [IdxW-1:0] idx;
    logic [DataW-1:0] val, mag;
    op_e op;

    idle_modes = '{0, 53, 9};
    hot[0] = '0;
    hot[1] = '1;
    for (int i = 2; i < 8; i++) hot[i] = 10'($urandom_range(0, 1023));
    foreach (neg_trend[i]) neg_trend[i] = 1'($urandom_range(0, 1));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset configuration
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                directed_rows[i].typed, directed_rows[i].weight, directed_rows[i].step);
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      // reconfigure while idle
      case (p)
        0: begin
          write_reg(CfgInitStep, 32'h0);
          write_reg(CfgMaxStep, 32'h0);
          write_reg(CfgWeightDecay, 32'h0);
        end
        1: begin
          write_reg(CfgInitStep, 32'hFFFF_FFFF);
          write_reg(CfgMaxStep, 32'h7FFF_FFFF);
          write_reg(CfgWeightDecay, 32'h8000_0000);
        end
        2: begin
          write_reg(CfgInitStep, 32'd20);
          write_reg(CfgMaxStep, 32'hFFFF_FFFF);
          write_reg(CfgWeightDecay, 32'h7FFF_FFFF);
        end
        3: begin
          write_reg(CfgInitStep, 32'd5000);
          write_reg(CfgMaxStep, 32'd3000);
          write_reg(CfgWeightDecay, 32'h0);
        end
        4: begin
          write_reg(CfgInitStep, 32'd1);
          write_reg(CfgMaxStep, 32'd1);
          write_reg(CfgWeightDecay, 32'h0010_0000);
        end
        5: begin
          write_reg(CfgUnused, $urandom);
          write_reg(CfgInitStep, 32'(DefInitStep));
          write_reg(CfgMaxStep, 32'(DefMaxStep));
          write_reg(CfgWeightDecay, 32'hFF00_0000);
        end
        default: begin
          write_reg(CfgInitStep, $urandom >> $urandom_range(0, 31));
          write_reg(CfgMaxStep, $urandom >> $urandom_range(0, 31));
          write_reg(CfgWeightDecay, $signed($urandom) >>> $urandom_range(0, 31));
        end
      endcase
      cfg_valid_i <= 1'b0;
      idle_pct = idle_modes[p % 3];
      flip_pct = (p % 2) ? 55 : 12;

      for (int n = 0; n < ItemsPerPhase; n++) begin
        // mostly a few busy weights so sequences run deep and collide
        idx = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                          : hot[$urandom_range(0, 7)];
        if (!loaded[idx] || $urandom_range(0, 9) == 0) begin
          op = OpLoad;
          val = ($urandom_range(0, 3) == 0) ? $signed($urandom)
                                            : $signed($urandom) >>> $urandom_range(4, 31);
        end else begin
          op = OpUpdate;
          if ($urandom_range(0, 99) < flip_pct) neg_trend[idx] = ~neg_trend[idx];
          r = $urandom_range(0, 99);
          if (r < 4) begin
            val = '0;
          end else if (r < 8) begin
            val = neg_trend[idx] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end else begin
            mag = $urandom >> $urandom_range(1, 31);
            val = neg_trend[idx] ? -mag : mag;
          end
        end
        send_item(op, idx, val, 1'b0, '0, '0);
      end
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("rprop_weight_update_test: PASS");
    end else begin
      $display("rprop_weight_update_test: FAIL");
    end
    $finish;
  end

endmodule
